/* hw/rtl/sset_pkg.sv */
// Package for the sorted sparse entry table.
// Holds the sequencer state type, opcode and status codes and the cell control struct.
// No dependencies.
package sset_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE
   } sset_state_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [1:0] STATUS_STORED  = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_READ    = 2'd3;

   // Broadcast control that every cell sees in the execute cycle.
   typedef struct packed {
      logic insert_en;
      logic read_en;
   } sset_bcast_type;

endpackage

/* hw/rtl/sset_cell.sv */
// One cell of the sorted entry chain: holds a single entry and its read hit flag.
// Depends on sset_pkg for the broadcast control struct.
module sset_cell import sset_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int COORD_BITS = 16,
   parameter int VALUE_BITS = 32,
   parameter int CNT_BITS   = 7,
   parameter int POS_BITS   = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sset_bcast_type          bcast,
   input  logic [CNT_BITS-1:0]     count,
   input  logic [POS_BITS-1:0]     position,
   input  logic [COORD_BITS-1:0]   new_row,
   input  logic [COORD_BITS-1:0]   new_col,
   input  logic [VALUE_BITS-1:0]   new_value,
   input  logic                    take_prev,
   input  logic [COORD_BITS-1:0]   prev_row,
   input  logic [COORD_BITS-1:0]   prev_col,
   input  logic [VALUE_BITS-1:0]   prev_value,
   output logic                    take,
   output logic [COORD_BITS-1:0]   row,
   output logic [COORD_BITS-1:0]   col,
   output logic [VALUE_BITS-1:0]   value,
   output logic [COORD_BITS-1:0]   rd_row,
   output logic [COORD_BITS-1:0]   rd_col,
   output logic [VALUE_BITS-1:0]   rd_value
);

   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  hit_ff, hit_in;
   logic                  occupied;

   assign occupied = CNT_BITS'(INDEX) < count;

   // The new entry lands in the first cell whose key is greater, or in the first
   // empty cell when no stored key is greater.
   assign take = occupied ? ({row_ff, col_ff} > {new_row, new_col})
                          : (CNT_BITS'(INDEX) == count);

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      value_in = value_ff;
      if (bcast.insert_en && take) begin
         if (take_prev) begin
            row_in   = prev_row;
            col_in   = prev_col;
            value_in = prev_value;
         end else begin
            row_in   = new_row;
            col_in   = new_col;
            value_in = new_value;
         end
      end
   end

   always_comb begin
      hit_in = 1'b0;
      if (bcast.read_en) begin
         hit_in = occupied && (POS_BITS'(INDEX) == position);
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign row      = row_ff;
   assign col      = col_ff;
   assign value    = value_ff;
   assign rd_row   = hit_ff ? row_ff   : '0;
   assign rd_col   = hit_ff ? col_ff   : '0;
   assign rd_value = hit_ff ? value_ff : '0;

endmodule

/* hw/rtl/sorted_sparse_entry_table.sv */
// Sorted sparse entry table: a chain of TABLE_DEPTH cells kept in row-major key order.
// The result strobe follows the accepting edge through the execute and reduce states and the output register.
// A new transaction is taken only when idle; busy covers the execute and reduce states,
// and the read reduce over all cells sets the second of them.
// Reset clears the entry count, the sequencer, the strobe and the cell hit flags; cell entries are not cleared.
// The receiver cannot stall: each result strobe is high for exactly one cycle.
module sorted_sparse_entry_table import sset_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [COORD_BITS-1:0]                 req_entry_row,
   input  logic [COORD_BITS-1:0]                 req_entry_col,
   input  logic signed [VALUE_BITS-1:0]          req_entry_value,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        req_read_position,
   output logic                                  rsp_strobe,
   output logic [COORD_BITS-1:0]                 rsp_out_row,
   output logic [COORD_BITS-1:0]                 rsp_out_col,
   output logic signed [VALUE_BITS-1:0]          rsp_out_value,
   output logic                                  rsp_out_valid,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]      rsp_entry_count,
   output logic [1:0]                            rsp_insert_status
);

   localparam int POS_BITS = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

   sset_state_type        state_ff, state_in;
   logic                  op_ff;
   logic [COORD_BITS-1:0] row_ff;
   logic [COORD_BITS-1:0] col_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [1:0]            status_ff, status_in;
   logic                  valid_ff, valid_in;
   logic                  strobe_ff, strobe_in;
   logic                  rsp_load;
   logic                  accept;
   sset_bcast_type        bcast;

   logic [COORD_BITS-1:0] rsp_row_ff, rsp_col_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_valid_ff;
   logic [CNT_BITS-1:0]   rsp_count_ff;
   logic [1:0]            rsp_status_ff;

   logic                  take_w  [TABLE_DEPTH];
   logic [COORD_BITS-1:0] row_w   [TABLE_DEPTH];
   logic [COORD_BITS-1:0] col_w   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_w [TABLE_DEPTH];
   logic [COORD_BITS-1:0] rd_row_w   [TABLE_DEPTH];
   logic [COORD_BITS-1:0] rd_col_w   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] rd_value_w [TABLE_DEPTH];
   logic [COORD_BITS-1:0] or_row;
   logic [COORD_BITS-1:0] or_col;
   logic [VALUE_BITS-1:0] or_value;

   assign accept = start && !busy;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      valid_in    = valid_ff;
      strobe_in   = 1'b0;
      rsp_load    = 1'b0;
      bcast       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REDUCE;
            valid_in = 1'b0;
            if (op_ff == OP_READ) begin
               bcast.read_en = 1'b1;
               status_in     = STATUS_READ;
               valid_in      = CNT_BITS'(pos_ff) < count_ff;
            end else if (value_ff == '0) begin
               status_in = STATUS_SKIPPED;
            end else if (count_ff == CNT_BITS'(TABLE_DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               bcast.insert_en = 1'b1;
               status_in       = STATUS_STORED;
               count_in        = count_ff + CNT_BITS'(1);
            end
         end
         ST_REDUCE: begin
            state_in  = ST_IDLE;
            rsp_load  = 1'b1;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      valid_ff  <= valid_in;
      if (accept) begin
         op_ff    <= req_opcode;
         row_ff   <= req_entry_row;
         col_ff   <= req_entry_col;
         value_ff <= req_entry_value;
         pos_ff   <= req_read_position;
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                  take_prev;
      logic [COORD_BITS-1:0] prev_row;
      logic [COORD_BITS-1:0] prev_col;
      logic [VALUE_BITS-1:0] prev_value;

      if (i == 0) begin : g_head
         assign take_prev  = 1'b0;
         assign prev_row   = '0;
         assign prev_col   = '0;
         assign prev_value = '0;
      end else begin : g_link
         assign take_prev  = take_w[i-1];
         assign prev_row   = row_w[i-1];
         assign prev_col   = col_w[i-1];
         assign prev_value = value_w[i-1];
      end

      sset_cell #(
         .INDEX      (i),
         .COORD_BITS (COORD_BITS),
         .VALUE_BITS (VALUE_BITS),
         .CNT_BITS   (CNT_BITS),
         .POS_BITS   (POS_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .count      (count_ff),
         .position   (pos_ff),
         .new_row    (row_ff),
         .new_col    (col_ff),
         .new_value  (value_ff),
         .take_prev  (take_prev),
         .prev_row   (prev_row),
         .prev_col   (prev_col),
         .prev_value (prev_value),
         .take       (take_w[i]),
         .row        (row_w[i]),
         .col        (col_w[i]),
         .value      (value_w[i]),
         .rd_row     (rd_row_w[i]),
         .rd_col     (rd_col_w[i]),
         .rd_value   (rd_value_w[i])
      );
   end

   // At most one cell holds its hit flag, so an OR over all cells selects it.
   always_comb begin
      or_row   = '0;
      or_col   = '0;
      or_value = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         or_row   = or_row   | rd_row_w[i];
         or_col   = or_col   | rd_col_w[i];
         or_value = or_value | rd_value_w[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff    <= or_row;
         rsp_col_ff    <= or_col;
         rsp_value_ff  <= or_value;
         rsp_valid_ff  <= valid_ff;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = strobe_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_out_valid     = rsp_valid_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_insert_status = rsp_status_ff;

endmodule

/* hw/rtl/sset_checker.sv */
// Port-level checker for the sorted sparse entry table, with its bind statement.
// Depends on sset_pkg for the status codes.
module sset_checker import sset_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 16,
   parameter int VALUE_BITS  = 32
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_strobe,
   input logic [COORD_BITS-1:0]                 rsp_out_row,
   input logic [COORD_BITS-1:0]                 rsp_out_col,
   input logic signed [VALUE_BITS-1:0]          rsp_out_value,
   input logic                                  rsp_out_valid,
   input logic [$clog2(TABLE_DEPTH+1)-1:0]      rsp_entry_count,
   input logic [1:0]                            rsp_insert_status
);

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

   // Every accepted transaction is followed by its result strobe.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result strobe missing after an accepted transaction");

   // No result arrives without a transaction accepted before it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result strobe without an accepted transaction");

   // Only a read transaction may report a valid entry.
   a_valid_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_valid) |-> (rsp_insert_status == STATUS_READ))
      else $error("valid entry reported for an insert transaction");

   // Entries without a valid flag read as zero.
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_valid) |->
         (rsp_out_row == '0 && rsp_out_col == '0 && rsp_out_value == '0))
      else $error("nonzero entry fields without a valid flag");

   // The table never reports more entries than it can hold.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_count <= CNT_BITS'(TABLE_DEPTH)))
      else $error("entry count above table depth");

endmodule

bind sorted_sparse_entry_table sset_checker #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .COORD_BITS  (COORD_BITS),
   .VALUE_BITS  (VALUE_BITS)
) u_sset_checker (.*);
